FILE: sv/assert_macros.svh
// assertion helpers for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, off while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication check, same clocking as above
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

FILE: sv/fba_pkg.sv
`default_nettype none
package fba_pkg;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NO_SPACE  = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [5:0]  slot;
    logic [11:0] len;
    logic [12:0] need;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        block_valid;
    logic [10:0] block_number;
    logic [5:0]  block_bytes;
    logic [11:0] used_blocks;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/fba_front.sv
`default_nettype none
module fba_front #(
  parameter int unsigned BLOCK_BYTES = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    req_type_i,
  input  wire logic [5:0]    file_slot_i,
  input  wire logic [11:0]   content_length_i,
  output fba_pkg::cmd_t      cmd_o,
  output logic               cmd_valid_o,
  input  wire logic          cmd_pop_i
);
  import fba_pkg::*;

  localparam int unsigned Payload = BLOCK_BYTES - 1;
  // reciprocal of the payload size, exact for dividends below 2**13
  localparam logic [26:0] Recip = 27'((64'd1 << 26) + 64'(Payload) - 64'd1) / 27'(Payload);

  logic [12:0] dividend;
  logic [39:0] product;
  cmd_t        cmd_new;
  cmd_t        q_mem [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        acc;

  assign dividend = 13'(content_length_i) + 13'(Payload - 1);
  assign product  = 40'(dividend) * 40'(Recip);

  always_comb begin
    cmd_new.req  = req_type_i;
    cmd_new.slot = file_slot_i;
    cmd_new.len  = content_length_i;
    cmd_new.need = product[38:26];
  end

  assign full        = cnt_q[1];
  assign acc         = push && !full;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (acc) q_mem[wr_ptr_q] <= cmd_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (acc) wr_ptr_q <= !wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(acc) - 2'(cmd_pop_i);
    end
  end

endmodule
`default_nettype wire

FILE: sv/fba_out_fifo.sv
`default_nettype none
module fba_out_fifo (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  fba_pkg::res_t  data_i,
  output logic           space_o,
  input  wire logic      pop,
  output logic           empty,
  output fba_pkg::res_t  data_o
);
  import fba_pkg::*;

  res_t       q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       deq;

  assign space_o = !cnt_q[1];
  assign empty   = cnt_q == 2'd0;
  assign deq     = pop && !empty;
  assign data_o  = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) q_mem[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (deq) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(deq);
    end
  end

endmodule
`default_nettype wire

FILE: sv/fba_back.sv
`default_nettype none
module fba_back #(
  parameter int unsigned NUM_BLOCKS      = 2048,
  parameter int unsigned BLOCK_BYTES     = 64,
  parameter int unsigned MAX_FILE_BLOCKS = 64,
  parameter int unsigned NUM_FILES       = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  fba_pkg::cmd_t  cmd_i,
  input  wire logic      cmd_valid_i,
  output logic           cmd_pop_o,
  output fba_pkg::res_t  res_o,
  output logic           res_push_o,
  input  wire logic      res_space_i
);
  import fba_pkg::*;

  localparam int unsigned Payload = BLOCK_BYTES - 1;
  localparam int unsigned FW  = $clog2(NUM_BLOCKS);
  localparam int unsigned CW  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned IW  = $clog2(MAX_FILE_BLOCKS + 1);
  localparam int unsigned SW  = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int unsigned MAW = (NUM_FILES * MAX_FILE_BLOCKS > 1) ?
                                $clog2(NUM_FILES * MAX_FILE_BLOCKS) : 1;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_META     = 10'b00_0000_0010,
    S_REL_RD   = 10'b00_0000_0100,
    S_REL_WR   = 10'b00_0000_1000,
    S_DECIDE   = 10'b00_0001_0000,
    S_ALLOC_RD = 10'b00_0010_0000,
    S_ALLOC_WR = 10'b00_0100_0000,
    S_EMIT_RD  = 10'b00_1000_0000,
    S_EMIT_WR  = 10'b01_0000_0000,
    S_RESP     = 10'b10_0000_0000
  } state_e;

  // slot modulo the slot count, one restoring step per slot bit
  function automatic logic [10:0] slot_mod(input logic [5:0] x);
    logic [10:0] r;
    r = '0;
    for (int i = 5; i >= 0; i--) begin
      r = {r[9:0], x[i]};
      if (r >= 11'(NUM_FILES)) r = r - 11'(NUM_FILES);
    end
    return r;
  endfunction

  logic [FW-1:0]  free_mem [NUM_BLOCKS];
  logic [FW-1:0]  map_mem  [NUM_FILES * MAX_FILE_BLOCKS];
  logic [IW-1:0]  cnt_mem  [NUM_FILES];
  logic [11:0]    size_mem [NUM_FILES];

  state_e         state_q, state_d;
  cmd_t           cmd_q;
  logic [SW-1:0]  slot_q, slot_new;
  logic [IW-1:0]  idx_q, n_q, cnt_now;
  logic [11:0]    rem_q, size_now, bytes;
  logic [CW-1:0]  used_q, used_now, free_cnt_q, fill_q;
  logic [1:0]     status_q, status_dec;
  logic [FW-1:0]  head_q, tail_q, fl_addr_q, fl_rd_q, map_rd_q, alloc_blk;
  logic           fl_hit_q;
  logic [IW-1:0]  cnt_rd_q;
  logic [11:0]    size_rd_q;
  logic [NUM_FILES-1:0] meta_vld_q;
  logic [MAW-1:0] map_addr;
  logic           last_blk, rel_push, meta_we, meta_fill, do_alloc, too_large, no_space;

  assign slot_new  = SW'(slot_mod(cmd_i.slot));
  assign map_addr  = MAW'(32'(slot_q) * 32'(MAX_FILE_BLOCKS) + 32'(idx_q));
  assign cnt_now   = meta_vld_q[slot_q] ? cnt_rd_q : '0;
  assign size_now  = meta_vld_q[slot_q] ? size_rd_q : '0;
  assign used_now  = CW'(NUM_BLOCKS) - free_cnt_q;
  assign last_blk  = IW'(idx_q + 1'b1) == n_q;
  assign bytes     = (rem_q > 12'(Payload)) ? 12'(Payload) : rem_q;
  assign rel_push  = (state_q == S_REL_WR) && (free_cnt_q < CW'(NUM_BLOCKS));
  assign alloc_blk = fl_hit_q ? fl_rd_q : fl_addr_q;
  assign too_large = cmd_q.need > 13'(MAX_FILE_BLOCKS);
  assign no_space  = 32'(cmd_q.need) > 32'(free_cnt_q);
  assign do_alloc  = (cmd_q.req == REQ_WRITE) && !too_large && !no_space &&
                     (cmd_q.need != 13'd0);
  assign meta_fill = (state_q == S_ALLOC_WR) && res_space_i && last_blk;
  assign meta_we   = (state_q == S_DECIDE) || meta_fill;
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  always_comb begin
    if (cmd_q.req == REQ_WRITE && too_large)     status_dec = ST_TOO_LARGE;
    else if (cmd_q.req == REQ_WRITE && no_space) status_dec = ST_NO_SPACE;
    else                                         status_dec = ST_OK;
  end

  always_comb begin
    res_push_o = res_space_i &&
                 (state_q == S_ALLOC_WR || state_q == S_EMIT_WR || state_q == S_RESP);
    if (state_q == S_RESP) begin
      res_o.status       = status_q;
      res_o.block_valid  = 1'b0;
      res_o.block_number = '0;
      res_o.block_bytes  = '0;
      res_o.used_blocks  = 12'(used_now);
      res_o.last         = 1'b1;
    end else begin
      res_o.status       = ST_OK;
      res_o.block_valid  = 1'b1;
      res_o.block_number = 11'((state_q == S_ALLOC_WR) ? alloc_blk : map_rd_q);
      res_o.block_bytes  = 6'(bytes);
      res_o.used_blocks  = 12'(used_q);
      res_o.last         = last_blk;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (cmd_valid_i) state_d = S_META;
      S_META: begin
        unique case (cmd_q.req)
          REQ_WRITE, REQ_DELETE: state_d = (cnt_now != '0) ? S_REL_RD : S_DECIDE;
          REQ_READ:              state_d = (cnt_now != '0) ? S_EMIT_RD : S_RESP;
          default:               state_d = S_RESP;
        endcase
      end
      S_REL_RD:   state_d = S_REL_WR;
      S_REL_WR:   state_d = last_blk ? S_DECIDE : S_REL_RD;
      S_DECIDE:   state_d = do_alloc ? S_ALLOC_RD : S_RESP;
      S_ALLOC_RD: state_d = S_ALLOC_WR;
      S_ALLOC_WR: if (res_space_i) state_d = last_blk ? S_IDLE : S_ALLOC_RD;
      S_EMIT_RD:  state_d = S_EMIT_WR;
      S_EMIT_WR:  if (res_space_i) state_d = last_blk ? S_IDLE : S_EMIT_RD;
      S_RESP:     if (res_space_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (rel_push) free_mem[tail_q] <= map_rd_q;
    if (state_q == S_ALLOC_RD) fl_rd_q <= free_mem[head_q];
    if (state_q == S_ALLOC_WR && res_space_i) map_mem[map_addr] <= alloc_blk;
    if (state_q == S_REL_RD || state_q == S_EMIT_RD) map_rd_q <= map_mem[map_addr];
    if (meta_we) begin
      cnt_mem[slot_q]  <= meta_fill ? n_q : '0;
      size_mem[slot_q] <= meta_fill ? cmd_q.len : '0;
    end
    if (cmd_pop_o) begin
      cnt_rd_q  <= cnt_mem[slot_new];
      size_rd_q <= size_mem[slot_new];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmd_q      <= '0;
      slot_q     <= '0;
      idx_q      <= '0;
      n_q        <= '0;
      rem_q      <= '0;
      used_q     <= '0;
      status_q   <= ST_OK;
      head_q     <= '0;
      tail_q     <= '0;
      free_cnt_q <= CW'(NUM_BLOCKS);
      fill_q     <= '0;
      fl_addr_q  <= '0;
      fl_hit_q   <= 1'b0;
      meta_vld_q <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_pop_o) begin
        cmd_q  <= cmd_i;
        slot_q <= slot_new;
      end
      if (meta_we) meta_vld_q[slot_q] <= 1'b1;
      unique case (state_q)
        S_META: begin
          n_q      <= cnt_now;
          rem_q    <= size_now;
          idx_q    <= '0;
          used_q   <= used_now;
          status_q <= (cmd_q.req == REQ_READ) ? ST_EMPTY : ST_OK;
        end
        S_REL_WR: begin
          idx_q <= IW'(idx_q + 1'b1);
          if (rel_push) begin
            tail_q     <= (tail_q == FW'(NUM_BLOCKS - 1)) ? '0 : FW'(tail_q + 1'b1);
            free_cnt_q <= CW'(free_cnt_q + 1'b1);
            // entries below the fill mark hold written data, the rest their index
            if (fill_q != CW'(NUM_BLOCKS)) fill_q <= CW'(fill_q + 1'b1);
          end
        end
        S_DECIDE: begin
          idx_q    <= '0;
          status_q <= status_dec;
          if (do_alloc) begin
            n_q    <= IW'(cmd_q.need);
            rem_q  <= cmd_q.len;
            used_q <= CW'(NUM_BLOCKS) - CW'(free_cnt_q - CW'(cmd_q.need));
          end
        end
        S_ALLOC_RD: begin
          fl_addr_q  <= head_q;
          fl_hit_q   <= CW'(head_q) < fill_q;
          head_q     <= (head_q == FW'(NUM_BLOCKS - 1)) ? '0 : FW'(head_q + 1'b1);
          free_cnt_q <= CW'(free_cnt_q - 1'b1);
        end
        S_ALLOC_WR, S_EMIT_WR: begin
          if (res_space_i) begin
            idx_q <= IW'(idx_q + 1'b1);
            rem_q <= rem_q - bytes;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/file_block_allocator_top.sv
// channel   | handshake          | beat
// request   | push / full        | req_type_i, file_slot_i, content_length_i
// result    | pop / empty        | status_o, block_valid_o, block_number_o, block_bytes_o,
//           |                    | used_blocks_o, last_o
// one request at a time in the back end, two queued ahead of it in the front
// per block, read: a map read and a beat (a status beat if empty); delete: a map read
// and a free list push; write: as delete for old blocks, then a free list read and a map
// write per new block (status beat if none), one access per step to a single-port memory
// reset: free list comes up full with no clearing pass (a fill mark stands for it)
// a full result queue stalls the back end; a busy back end fills the request queue
`default_nettype none
`include "assert_macros.svh"
module file_block_allocator_top #(
  parameter int unsigned NUM_BLOCKS      = 2048,
  parameter int unsigned BLOCK_BYTES     = 64,
  parameter int unsigned MAX_FILE_BLOCKS = 64,
  parameter int unsigned NUM_FILES       = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [5:0]  file_slot_i,
  input  wire logic [11:0] content_length_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status_o,
  output logic             block_valid_o,
  output logic [10:0]      block_number_o,
  output logic [5:0]       block_bytes_o,
  output logic [11:0]      used_blocks_o,
  output logic             last_o
);
  import fba_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_space;

  fba_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
    .clk_i, .rst_ni, .push, .full, .req_type_i, .file_slot_i, .content_length_i,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop)
  );

  fba_back #(
    .NUM_BLOCKS(NUM_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES),
    .MAX_FILE_BLOCKS(MAX_FILE_BLOCKS), .NUM_FILES(NUM_FILES)
  ) u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop),
    .res_o(res_in), .res_push_o(res_push), .res_space_i(res_space)
  );

  fba_out_fifo u_out (
    .clk_i, .rst_ni, .push_i(res_push), .data_i(res_in), .space_o(res_space),
    .pop, .empty, .data_o(res_out)
  );

  assign status_o       = res_out.status;
  assign block_valid_o  = res_out.block_valid;
  assign block_number_o = res_out.block_number;
  assign block_bytes_o  = res_out.block_bytes;
  assign used_blocks_o  = res_out.used_blocks;
  assign last_o         = res_out.last;

  `ASSERT_IMPL(a_res_space, res_push, res_space, "result beat pushed into a full queue")
  `ASSERT_IMPL(a_cmd_avail, cmd_pop, cmd_valid, "command taken from an empty queue")
  `ASSERT_IMPL(a_blk_ok, res_push && res_in.block_valid, res_in.status == ST_OK, "block beat with a failing status")

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import fba_pkg::*;

  localparam int NBLK = 2048;
  localparam int PAY = 63;
  localparam int MAXB = 64;
  localparam int NFILES = 64;
  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] req_type_i = '0;
  logic [5:0] file_slot_i = '0;
  logic [11:0] content_length_i = '0;
  logic full, empty;
  logic [1:0] status_o;
  logic block_valid_o;
  logic [10:0] block_number_o;
  logic [5:0] block_bytes_o;
  logic [11:0] used_blocks_o;
  logic last_o;

  file_block_allocator_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .req_type_i(req_type_i), .file_slot_i(file_slot_i),
    .content_length_i(content_length_i), .empty(empty), .pop(pop),
    .status_o(status_o), .block_valid_o(block_valid_o),
    .block_number_o(block_number_o), .block_bytes_o(block_bytes_o),
    .used_blocks_o(used_blocks_o), .last_o(last_o)
  );

  always #1 clk_i = ~clk_i;

  // allocator shadow state
  logic [10:0] free_blocks [NBLK];
  int unsigned fhead, ftail, fcount;
  logic [10:0] blk_map [NFILES][MAXB];
  int unsigned blk_cnt [NFILES];
  int unsigned fsize [NFILES];

  res_t pending_results [$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit quiet_rx = 1'b0;

  task automatic free_block(input logic [10:0] b);
    if (fcount < NBLK) begin
      free_blocks[ftail] = b;
      ftail = (ftail + 1) % NBLK;
      fcount++;
    end
  endtask

  task automatic release_file(input int s);
    for (int i = 0; i < blk_cnt[s]; i++) free_block(blk_map[s][i]);
    blk_cnt[s] = 0;
    fsize[s] = 0;
  endtask

  task automatic allocate_request(input logic [1:0] rq, input logic [5:0] sl,
                                  input logic [11:0] ln);
    res_t batch [$];
    res_t r;
    int s, need, rem, b;
    s = sl;
    batch = {};
    r = '0;
    r.last = 1'b1;
    if (rq == REQ_WRITE) begin
      release_file(s);
      need = (ln + PAY - 1) / PAY;
      if (need > MAXB) begin
        r.status = ST_TOO_LARGE;
        batch.push_back(r);
      end else if (need > fcount) begin
        r.status = ST_NO_SPACE;
        batch.push_back(r);
      end else if (need == 0) begin
        batch.push_back(r);
      end else begin
        for (int i = 0; i < need; i++) begin
          blk_map[s][i] = free_blocks[fhead];
          fhead = (fhead + 1) % NBLK;
          fcount--;
        end
        blk_cnt[s] = need;
        fsize[s] = ln;
      end
    end else if (rq == REQ_READ) begin
      if (blk_cnt[s] == 0) begin
        r.status = ST_EMPTY;
        batch.push_back(r);
      end
    end else if (rq == REQ_DELETE) begin
      release_file(s);
      batch.push_back(r);
    end else begin
      batch.push_back(r);
    end
    // block list for a successful write or a read of a non-empty file
    if (batch.size() == 0) begin
      rem = fsize[s];
      for (int i = 0; i < blk_cnt[s]; i++) begin
        b = rem > PAY ? PAY : rem;
        rem -= b;
        r = '0;
        r.status = ST_OK;
        r.block_valid = 1'b1;
        r.block_number = blk_map[s][i];
        r.block_bytes = b[5:0];
        r.last = (i + 1 == blk_cnt[s]);
        batch.push_back(r);
      end
    end
    foreach (batch[i]) begin
      batch[i].used_blocks = 12'(NBLK - fcount);
      pending_results.push_back(batch[i]);
    end
  endtask

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // push stays high after a beat so that a back-to-back beat needs one assignment only
  task automatic send_request(input logic [1:0] rq, input logic [5:0] sl,
                              input logic [11:0] ln);
    int g;
    g = quiet_rx ? 0 : short_or_long_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    push <= 1'b1;
    req_type_i <= rq;
    file_slot_i <= sl;
    content_length_i <= ln;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    allocate_request(rq, sl, ln);
    @(negedge clk_i);
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off || (!quiet_rx && $urandom_range(0, 3) == 0)) pop <= 1'b0;
      else pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected beat: status %0d blk %0d", $time, status_o,
                 block_number_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || block_valid_o !== want.block_valid ||
            block_number_o !== want.block_number || block_bytes_o !== want.block_bytes ||
            used_blocks_o !== want.used_blocks || last_o !== want.last) begin
          $display("%0t mismatch: expected st %0d v %0d blk %0d by %0d used %0d last %0d",
                   $time, want.status, want.block_valid, want.block_number,
                   want.block_bytes, want.used_blocks, want.last);
          $display("%0t           actual   st %0d v %0d blk %0d by %0d used %0d last %0d",
                   $time, status_o, block_valid_o, block_number_o, block_bytes_o,
                   used_blocks_o, last_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat on either side, paused during a hold-off
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(REQ_READ, 6'd0, 12'd0);
    send_request(REQ_WRITE, 6'd0, 12'd0);
    send_request(REQ_WRITE, 6'd0, 12'd1);
    send_request(REQ_WRITE, 6'd1, 12'd63);
    send_request(REQ_WRITE, 6'd2, 12'd64);
    send_request(REQ_WRITE, 6'd63, 12'd4032);
    send_request(REQ_WRITE, 6'd3, 12'd4033);
    send_request(REQ_WRITE, 6'd4, 12'd4095);
    send_request(REQ_READ, 6'd63, 12'd4095);
    send_request(REQ_READ, 6'd1, 12'd0);
    send_request(REQ_WRITE, 6'd1, 12'd200);
    send_request(REQ_DELETE, 6'd2, 12'd0);
    send_request(REQ_DELETE, 6'd5, 12'd0);
    send_request(2'd3, 6'd42, 12'd2730);
    send_request(REQ_READ, 6'd2, 12'd1365);
  endtask

  // fill the disk with large files so that a write runs out of space
  task automatic test_no_space();
    for (int s = 8; s < 42; s++) send_request(REQ_WRITE, 6'(s), 12'd4032);
    send_request(REQ_WRITE, 6'd42, 12'd2000);
    send_request(REQ_READ, 6'd42, 12'd0);
    for (int s = 8; s < 42; s++) send_request(REQ_DELETE, 6'(s), 12'd0);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    quiet_rx = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_request(REQ_WRITE, 6'($urandom_range(0, 63)), 12'($urandom_range(0, 300)));
    join
    quiet_rx = 1'b0;
  endtask

  task automatic test_random();
    logic [1:0] rq;
    logic [11:0] ln;
    int pick;
    for (int i = 0; i < 24; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) rq = REQ_WRITE;
      else if (pick < 15) rq = REQ_READ;
      else if (pick < 19) rq = REQ_DELETE;
      else rq = 2'd3;
      pick = $urandom_range(0, 9);
      if (pick < 6) ln = 12'($urandom_range(0, 400));
      else if (pick < 9) ln = 12'($urandom_range(0, 4032));
      else ln = 12'($urandom);
      send_request(rq, 6'($urandom_range(0, 63)), ln);
    end
  endtask

  initial begin
    for (int i = 0; i < NBLK; i++) free_blocks[i] = 11'(i);
    fhead = 0;
    ftail = 0;
    fcount = NBLK;
    for (int s = 0; s < NFILES; s++) begin
      blk_cnt[s] = 0;
      fsize[s] = 0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_directed();
    test_no_space();
    test_backpressure();
    test_random();
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: file_block_allocator_top.f
+incdir+sv
sv/fba_pkg.sv
sv/fba_front.sv
sv/fba_out_fifo.sv
sv/fba_back.sv
sv/file_block_allocator_top.sv
tb/tb.sv
